[design/ehcs_pkg.sv]
// ----------------------------------------------------------------------------
// ehcs_pkg
// Shared types, constants and the key text for the header compression scanner.
// ----------------------------------------------------------------------------
package ehcs_pkg;

    localparam int OFFSET_BITS = 32;
    localparam int CFG_W       = 32;
    localparam int BYTE_W      = 8;
    // compare width for offset, length and size sums, with carry room
    localparam int CMP_W       = ((OFFSET_BITS > CFG_W) ? OFFSET_BITS : CFG_W) + 2;

    localparam logic [OFFSET_BITS-1:0] MAGIC_LAST_OFF = OFFSET_BITS'(7);
    localparam logic [OFFSET_BITS-1:0] OFFSET_MAX     = {OFFSET_BITS{1'b1}};

    localparam logic [3:0] KEY_LEN      = 4'd11;
    localparam logic [3:0] NAME_POS_MAX = 4'd12;
    localparam logic [1:0] SIZE_LAST    = 2'd3;

    typedef struct packed {
        logic              emit;
        logic              found;
        logic [BYTE_W-1:0] code;
    } ehcs_result_t;

    // "compression", one character per name position
    function automatic logic [BYTE_W-1:0] key_char(input logic [3:0] pos);
        logic [BYTE_W-1:0] c;
        case (pos)
            4'd0:    c = 8'h63; // c
            4'd1:    c = 8'h6f; // o
            4'd2:    c = 8'h6d; // m
            4'd3:    c = 8'h70; // p
            4'd4:    c = 8'h72; // r
            4'd5:    c = 8'h65; // e
            4'd6:    c = 8'h73; // s
            4'd7:    c = 8'h73; // s
            4'd8:    c = 8'h69; // i
            4'd9:    c = 8'h6f; // o
            4'd10:   c = 8'h6e; // n
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

[design/ehcs_if.sv]
// ----------------------------------------------------------------------------
// ehcs_if
// Valid/ready channel interfaces: byte stream, scan result and config write.
// ----------------------------------------------------------------------------
interface ehcs_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface ehcs_result_if;
    logic       valid;
    logic       ready;
    logic       found;
    logic [7:0] compression_code;

    modport source (output valid, output found, output compression_code, input ready);
    modport sink   (input valid, input found, input compression_code, output ready);
endinterface

interface ehcs_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[design/ehcs_scan.sv]
// ----------------------------------------------------------------------------
// ehcs_scan
// Header walker: tracks phase, offset, name match and size for each byte.
// ----------------------------------------------------------------------------
module ehcs_scan
    import ehcs_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    byte_accept,
    input  logic [BYTE_W-1:0]       data_byte,
    input  logic                    last_byte,
    input  logic                    cfg_we,
    input  logic [CFG_W-1:0]        cfg_data,
    output ehcs_result_t            result
);

    typedef enum logic [2:0] {
        PH_MAGIC       = 3'd0,
        PH_NAME        = 3'd1,
        PH_TYPE        = 3'd2,
        PH_SIZE        = 3'd3,
        PH_VALUE_FIRST = 3'd4,
        PH_VALUE_SKIP  = 3'd5
    } phase_t;

    phase_t                 phase_reg, phase_next;
    logic [OFFSET_BITS-1:0] offset_reg, offset_next;
    logic [3:0]             name_pos_reg, name_pos_next;
    logic                   name_match_reg, name_match_next;
    logic [CFG_W-1:0]       size_acc_reg, size_acc_next;
    logic [1:0]             size_cnt_reg, size_cnt_next;
    logic [CFG_W-1:0]       value_left_reg, value_left_next;
    logic                   answer_reg, answer_next;
    logic [CFG_W-1:0]       stream_length_reg;

    logic [CMP_W-1:0]       off_ext;
    logic [CMP_W-1:0]       len_ext;
    logic [CFG_W-1:0]       size_full;
    logic                   past_end;
    logic                   overrun;
    logic                   emit;
    logic                   found;
    logic [BYTE_W-1:0]      code;
    logic [CFG_W-1:0]       value_dec;

    assign off_ext   = CMP_W'(offset_reg);
    assign len_ext   = CMP_W'(stream_length_reg);
    assign past_end  = off_ext >= len_ext;
    assign size_full = size_acc_reg | (CFG_W'(data_byte) << {size_cnt_reg, 3'b000});
    assign overrun   = (CMP_W'(size_full) + off_ext + CMP_W'(1)) > len_ext;
    assign value_dec = (value_left_reg != '0) ? value_left_reg - CFG_W'(1) : value_left_reg;

    always_comb
    begin
        phase_next      = phase_reg;
        offset_next     = offset_reg;
        name_pos_next   = name_pos_reg;
        name_match_next = name_match_reg;
        size_acc_next   = size_acc_reg;
        size_cnt_next   = size_cnt_reg;
        value_left_next = value_left_reg;
        answer_next     = answer_reg;
        emit            = 1'b0;
        found           = 1'b0;
        code            = '0;

        if (!answer_reg)
        begin
            if (past_end)
            begin
                emit = 1'b1;
            end
            else
            begin
                case (phase_reg)
                    PH_MAGIC:
                    begin
                        if (offset_reg == MAGIC_LAST_OFF)
                        begin
                            phase_next      = PH_NAME;
                            name_pos_next   = '0;
                            name_match_next = 1'b1;
                        end
                    end
                    PH_NAME:
                    begin
                        if (data_byte == '0)
                        begin
                            // empty name ends the header
                            if (name_pos_reg == '0)
                            begin
                                emit = 1'b1;
                            end
                            else
                            begin
                                name_match_next = name_match_reg && (name_pos_reg == KEY_LEN);
                                phase_next      = PH_TYPE;
                            end
                        end
                        else
                        begin
                            if (!(name_pos_reg < KEY_LEN && data_byte == key_char(name_pos_reg)))
                            begin
                                name_match_next = 1'b0;
                            end
                            if (name_pos_reg < NAME_POS_MAX)
                            begin
                                name_pos_next = name_pos_reg + 4'd1;
                            end
                        end
                    end
                    PH_TYPE:
                    begin
                        if (data_byte == '0)
                        begin
                            phase_next    = PH_SIZE;
                            size_acc_next = '0;
                            size_cnt_next = '0;
                        end
                    end
                    PH_SIZE:
                    begin
                        size_acc_next = size_full;
                        if (size_cnt_reg == SIZE_LAST)
                        begin
                            if (size_full[CFG_W-1] || overrun)
                            begin
                                emit = 1'b1;
                            end
                            else if (name_match_reg && size_full != '0)
                            begin
                                phase_next = PH_VALUE_FIRST;
                            end
                            else if (size_full == '0)
                            begin
                                phase_next      = PH_NAME;
                                name_pos_next   = '0;
                                name_match_next = 1'b1;
                            end
                            else
                            begin
                                value_left_next = size_full;
                                phase_next      = PH_VALUE_SKIP;
                            end
                        end
                        else
                        begin
                            size_cnt_next = size_cnt_reg + 2'd1;
                        end
                    end
                    PH_VALUE_FIRST:
                    begin
                        emit  = 1'b1;
                        found = 1'b1;
                        code  = data_byte;
                    end
                    PH_VALUE_SKIP:
                    begin
                        value_left_next = value_dec;
                        if (value_dec == '0)
                        begin
                            phase_next      = PH_NAME;
                            name_pos_next   = '0;
                            name_match_next = 1'b1;
                        end
                    end
                    default:
                    begin
                        emit = 1'b1;
                    end
                endcase
            end
            if (emit)
            begin
                answer_next = 1'b1;
            end
            offset_next = (offset_reg != OFFSET_MAX) ? offset_reg + OFFSET_BITS'(1) : OFFSET_MAX;
        end

        // end of file: report not-found if undecided, then rearm
        if (last_byte)
        begin
            if (!answer_next)
            begin
                emit  = 1'b1;
                found = 1'b0;
                code  = '0;
            end
            phase_next      = PH_MAGIC;
            offset_next     = '0;
            name_pos_next   = '0;
            name_match_next = 1'b1;
            size_acc_next   = '0;
            size_cnt_next   = '0;
            value_left_next = '0;
            answer_next     = 1'b0;
        end
    end

    assign result.emit  = byte_accept && emit;
    assign result.found = found;
    assign result.code  = code;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_MAGIC;
            offset_reg        <= '0;
            name_pos_reg      <= '0;
            name_match_reg    <= 1'b1;
            size_acc_reg      <= '0;
            size_cnt_reg      <= '0;
            value_left_reg    <= '0;
            answer_reg        <= 1'b0;
            stream_length_reg <= '0;
        end
        else
        begin
            if (byte_accept)
            begin
                phase_reg      <= phase_next;
                offset_reg     <= offset_next;
                name_pos_reg   <= name_pos_next;
                name_match_reg <= name_match_next;
                size_acc_reg   <= size_acc_next;
                size_cnt_reg   <= size_cnt_next;
                value_left_reg <= value_left_next;
                answer_reg     <= answer_next;
            end
            if (cfg_we)
            begin
                stream_length_reg <= cfg_data;
            end
        end
    end

    // once answered, the offset holds until the file ends
    a_offset_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        byte_accept && answer_reg && !last_byte |=> $stable(offset_reg))
        else $error("offset advanced after the answer was given");

    // a found result comes only from the first value byte
    a_found_phase: assert property (@(posedge clk) disable iff (!rst_n)
        result.emit && result.found |-> phase_reg == PH_VALUE_FIRST && !answer_reg)
        else $error("found reported outside the first value byte");

    // last byte rearms the walker
    a_rearm: assert property (@(posedge clk) disable iff (!rst_n)
        byte_accept && last_byte |=> phase_reg == PH_MAGIC && offset_reg == '0 && !answer_reg)
        else $error("scanner not rearmed after last byte");

    // at most one result per file
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        byte_accept && answer_reg && !last_byte |-> !result.emit)
        else $error("second result in one file");

endmodule

[design/ehcs_out_reg.sv]
// ----------------------------------------------------------------------------
// ehcs_out_reg
// Result register: holds one result until the sink takes it.
// ----------------------------------------------------------------------------
module ehcs_out_reg
    import ehcs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  ehcs_result_t         result,
    output logic                 can_load,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 out_found,
    output logic [BYTE_W-1:0]    out_code
);

    logic              valid_reg;
    logic              found_reg;
    logic [BYTE_W-1:0] code_reg;

    // free when empty or draining this cycle
    assign can_load  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_found = found_reg;
    assign out_code  = code_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (result.emit)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result.emit)
        begin
            found_reg <= result.found;
            code_reg  <= result.code;
        end
    end

    // never overwrite a result that is still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        result.emit |-> can_load)
        else $error("result overwritten before transaction");

    // not-found always carries a zero code
    a_zero_code: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !found_reg |-> code_reg == '0)
        else $error("nonzero code on not-found result");

    // a loaded result is presented on the next cycle
    a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
        result.emit |=> valid_reg)
        else $error("loaded result not presented");

endmodule

[design/exr_header_compression_scan_top.sv]
// Result: registered; it appears in the cycle after its deciding byte is taken.
// Throughput: one byte per cycle; the byte input stalls only while a result waits
// in the output register and the sink is not ready.
// Reset: rst_n clears the walker, the output register and stream_length (to 0);
// a transaction with last_byte set rearms the walker and keeps stream_length.
// ----------------------------------------------------------------------------
// exr_header_compression_scan_top
// Scans an image file byte stream for the compression header attribute.
// ----------------------------------------------------------------------------
module exr_header_compression_scan_top
    import ehcs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    ehcs_byte_if.sink            bytes,
    ehcs_result_if.source        result,
    ehcs_cfg_if.sink             cfg
);

    ehcs_result_t scan_result;
    logic         can_load;
    logic         byte_accept;

    assign bytes.ready = can_load;
    assign byte_accept = bytes.valid && can_load;
    assign cfg.ready   = 1'b1;

    ehcs_scan u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_accept (byte_accept),
        .data_byte   (bytes.data_byte),
        .last_byte   (bytes.last_byte),
        .cfg_we      (cfg.valid),
        .cfg_data    (cfg.data),
        .result      (scan_result)
    );

    ehcs_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .result    (scan_result),
        .can_load  (can_load),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .out_found (result.found),
        .out_code  (result.compression_code)
    );

endmodule
